// File: sv/angle_bias_kalman_filter_defines.svh
// Assertion macros for the angle/bias Kalman filter.
// Used by the top level; expects clk and rst in scope.
`ifndef ANGLE_BIAS_KALMAN_FILTER_DEFINES_SVH
`define ANGLE_BIAS_KALMAN_FILTER_DEFINES_SVH

// same-cycle implication
`define ABKF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ABKF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/abkf_pkg.sv
// Shared types, codes and helpers for the angle/bias Kalman filter.
// No dependencies.
`timescale 1ns / 1ps
package abkf_pkg;

  localparam int unsigned CfgW = 48;
  localparam logic [CfgW-1:0] QANGLE_RST = 48'd1099511628;
  localparam logic [CfgW-1:0] QBIAS_RST  = 48'd3298534883;
  localparam logic [CfgW-1:0] RNOISE_RST = 48'd32985348833;
  localparam logic [24:0] DT_ONE = 25'd16777216;

  typedef enum logic [1:0] {
    REG_QANGLE = 2'd0,
    REG_QBIAS  = 2'd1,
    REG_RNOISE = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    MUL_Q16,
    MUL_Q24,
    MUL_Q40
  } mul_mode_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RATE, ST_T, ST_INNER, ST_PQB, ST_K0, ST_K1, ST_ANG,
    ST_BIAS, ST_P0, ST_P1, ST_P2, ST_P3, ST_OUT, ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [47:0] val;
    logic               sat;
  } clip_t;

  localparam logic signed [63:0] C48_MAX = 64'sd140737488355327;
  localparam logic signed [63:0] C48_MIN = -64'sd140737488355328;

  function automatic clip_t clip48(input logic signed [63:0] v);
    clip_t r;
    r.sat = 1'b0;
    if (v > C48_MAX) begin
      r.val = C48_MAX[47:0];
      r.sat = 1'b1;
    end else if (v < C48_MIN) begin
      r.val = C48_MIN[47:0];
      r.sat = 1'b1;
    end else begin
      r.val = v[47:0];
    end
    return r;
  endfunction

endpackage

// File: sv/abkf_mul.sv
// Shared signed multiplier: four 32x32 partial products accumulated, then
// round half away from zero, shift and clip. Depends on abkf_pkg.
`timescale 1ns / 1ps
module abkf_mul (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  abkf_pkg::mul_mode_t     mode,
  input  logic signed [63:0]      a,
  input  logic signed [63:0]      b,
  output logic                    done,
  output logic signed [63:0]      res,
  output logic                    sat
);
  import abkf_pkg::*;

  logic [63:0]  x;
  logic [63:0]  y;
  logic         neg;
  mul_mode_t    mode_r;
  logic [127:0] acc;
  logic [2:0]   cnt;
  logic         busy;

  logic [31:0]  xs;
  logic [31:0]  ys;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [127:0] rnd;
  logic [127:0] shifted;
  logic [63:0]  lim;
  logic         over;
  logic [63:0]  m;

  always_comb begin
    xs = cnt[1] ? x[63:32] : x[31:0];
    ys = cnt[0] ? y[63:32] : y[31:0];
    pp = 64'(xs) * 64'(ys);
    case (cnt[1:0])
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    case (mode_r)
      MUL_Q16: begin
        rnd = 128'd1 << 15;
        shifted = acc >> 16;
        lim = neg ? (64'd1 << 31) : (64'd1 << 31) - 64'd1;
      end
      MUL_Q24: begin
        rnd = 128'd1 << 23;
        shifted = acc >> 24;
        lim = neg ? (64'd1 << 61) : (64'd1 << 61) - 64'd1;
      end
      default: begin
        rnd = 128'd1 << 39;
        shifted = acc >> 40;
        lim = neg ? (64'd1 << 61) : (64'd1 << 61) - 64'd1;
      end
    endcase
    over = shifted > {64'd0, lim};
    m = over ? lim : shifted[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x      <= a[63] ? 64'(-a) : 64'(a);
        y      <= b[63] ? 64'(-b) : 64'(b);
        neg    <= a[63] ^ b[63];
        mode_r <= mode;
        acc    <= '0;
        cnt    <= '0;
        busy   <= 1'b1;
      end else if (busy) begin
        if (cnt < 3'd4) begin
          acc <= acc + pp_sh;
          cnt <= cnt + 3'd1;
        end else if (cnt == 3'd4) begin
          acc <= acc + rnd;
          cnt <= cnt + 3'd1;
        end else begin
          res  <= neg ? -$signed(m) : $signed(m);
          sat  <= over;
          done <= 1'b1;
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// File: sv/abkf_div.sv
// Restoring divider: n * 2^40 / d, one quotient bit per cycle,
// truncated toward zero, clipped to 48 bits, zero for d == 0. Uses abkf_pkg.
`timescale 1ns / 1ps
module abkf_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] n,
  input  logic signed [63:0] d,
  output logic               done,
  output logic signed [47:0] res,
  output logic               sat
);
  import abkf_pkg::*;

  logic [87:0] num;
  logic [49:0] ud;
  logic [49:0] rem;
  logic [46:0] q;
  logic [6:0]  cnt;
  logic        neg;
  logic        dzero;
  logic        over;
  logic        busy;
  logic        fin;

  logic [50:0] r2;
  logic        qbit;
  logic [63:0] un;
  logic [63:0] udm;

  always_comb begin
    r2   = {rem, num[87]};
    qbit = r2 >= {1'b0, ud};
    un   = n[63] ? 64'(-n) : 64'(n);
    udm  = d[63] ? 64'(-d) : 64'(d);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        num   <= {un[47:0], 40'd0};
        ud    <= udm[49:0];
        rem   <= '0;
        q     <= '0;
        cnt   <= 7'd87;
        neg   <= n[63] ^ d[63];
        dzero <= (d == 64'sd0);
        over  <= 1'b0;
        busy  <= 1'b1;
      end else if (busy) begin
        num <= {num[86:0], 1'b0};
        rem <= qbit ? 50'(r2 - {1'b0, ud}) : r2[49:0];
        if (cnt >= 7'd47) begin
          over <= over | qbit;
        end else begin
          q <= {q[45:0], qbit};
        end
        if (cnt == 7'd0) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end else begin
          cnt <= cnt - 7'd1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
        sat  <= over && !dzero;
        if (dzero) begin
          res <= '0;
        end else if (over) begin
          res <= neg ? C48_MIN[47:0] : C48_MAX[47:0];
        end else begin
          res <= neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        end
      end
    end
  end

endmodule

// File: sv/angle_bias_kalman_filter.sv
// Two-state (angle, gyro bias) Kalman filter for one tilt axis.
// Depends on abkf_pkg, abkf_mul, abkf_div and the assertion macro header.
//
// One transaction in gives one transaction out. Each item runs through a
// sequencer that drives one shared multiplier (11 products) and one bit-serial
// divider (2 gains); most of the time for each item goes to the divider.
// Input is accepted only while the sequencer is idle; a finished result waits
// in the output register while the next item is taken. If the previous result
// has not left yet, the sequencer holds the new one until it does.
// Configuration writes go to the noise registers and must happen while the
// block is idle.
`timescale 1ns / 1ps
`include "angle_bias_kalman_filter_defines.svh"
module angle_bias_kalman_filter (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // angle_in[31:0], gyro_rate[63:32], accel_angle[95:64], time_step[120:96]
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // angle_out[31:0]
  output logic [31:0]  m_axis_tdata,
  // saturated[0]
  output logic [0:0]   m_axis_tuser,
  input  logic         wr_en,
  input  logic [1:0]   wr_index,
  input  logic [abkf_pkg::CfgW-1:0] wr_data
);
  import abkf_pkg::*;

  state_t state;
  state_t state_next;

  logic [CfgW-1:0] q_angle;
  logic [CfgW-1:0] q_bias;
  logic [CfgW-1:0] r_noise;

  logic signed [47:0] bias;
  logic signed [47:0] p00;
  logic signed [47:0] p01;
  logic signed [47:0] p10;
  logic signed [47:0] p11;
  logic signed [47:0] ang;
  logic signed [47:0] k0;
  logic signed [47:0] k1;
  logic signed [47:0] p00o;
  logic signed [47:0] p01o;
  logic signed [63:0] ainw;
  logic signed [63:0] accw;
  logic signed [63:0] rate;
  logic signed [63:0] tt;
  logic signed [63:0] dt;
  logic               sat;
  logic               issued;

  logic [31:0]        out_angle;
  logic               out_sat;
  logic               out_valid;

  logic               mul_start;
  mul_mode_t          mul_mode;
  logic signed [63:0] mul_a;
  logic signed [63:0] mul_b;
  logic               mul_done;
  logic signed [63:0] mul_res;
  logic               mul_sat;

  logic               div_start;
  logic signed [63:0] div_n;
  logic signed [63:0] div_d;
  logic               div_done;
  logic signed [47:0] div_res;
  logic               div_sat;

  logic               unit_done;
  logic               load;
  logic               in_fire;
  logic signed [63:0] sum;
  logic signed [63:0] inner;
  logic signed [63:0] s_var;
  logic signed [63:0] y_inn;
  clip_t              cl;
  clip_t              cl1;
  clip_t              cl2;
  logic [24:0]        ts;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_angle;
  assign m_axis_tuser  = out_sat;
  assign unit_done     = mul_done || div_done;
  assign load          = (state == ST_DONE) && (!out_valid || m_axis_tready);
  assign ts            = s_axis_tdata[120:96];

  always_comb begin
    inner = tt - 64'(p01) - 64'(p10) + $signed({16'd0, q_angle});
    s_var = 64'(p00) + $signed({16'd0, r_noise});
    case (state)
      ST_RATE:  sum = ainw + mul_res;
      ST_INNER: sum = 64'(p00) + mul_res;
      ST_PQB:   sum = 64'(p11) + mul_res;
      ST_ANG:   sum = 64'(ang) + mul_res;
      ST_BIAS:  sum = 64'(bias) + mul_res;
      ST_P0:    sum = 64'(p00) - mul_res;
      ST_P1:    sum = 64'(p01) - mul_res;
      ST_P2:    sum = 64'(p10) - mul_res;
      ST_P3:    sum = 64'(p11) - mul_res;
      default:  sum = mul_res;
    endcase
    cl  = clip48(sum);
    cl1 = clip48(64'(p01) - tt);
    cl2 = clip48(64'(p10) - tt);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_fire) state_next = ST_RATE;
      ST_RATE:  if (unit_done) state_next = ST_T;
      ST_T:     if (unit_done) state_next = ST_INNER;
      ST_INNER: if (unit_done) state_next = ST_PQB;
      ST_PQB:   if (unit_done) state_next = ST_K0;
      ST_K0:    if (unit_done) state_next = ST_K1;
      ST_K1:    if (unit_done) state_next = ST_ANG;
      ST_ANG:   if (unit_done) state_next = ST_BIAS;
      ST_BIAS:  if (unit_done) state_next = ST_P0;
      ST_P0:    if (unit_done) state_next = ST_P1;
      ST_P1:    if (unit_done) state_next = ST_P2;
      ST_P2:    if (unit_done) state_next = ST_P3;
      ST_P3:    if (unit_done) state_next = ST_OUT;
      ST_OUT:   if (unit_done) state_next = ST_DONE;
      ST_DONE:  if (load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // unit operands
  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_mode  = MUL_Q24;
    mul_a     = dt;
    mul_b     = rate;
    div_n     = 64'(p00);
    div_d     = s_var;
    case (state)
      ST_RATE:  mul_start = !issued;
      ST_T: begin
        mul_start = !issued;
        mul_b     = 64'(p11);
      end
      ST_INNER: begin
        mul_start = !issued;
        mul_b     = inner;
      end
      ST_PQB: begin
        mul_start = !issued;
        mul_a     = $signed({16'd0, q_bias});
        mul_b     = dt;
      end
      ST_K0:    div_start = !issued;
      ST_K1: begin
        div_start = !issued;
        div_n     = 64'(p10);
      end
      ST_ANG: begin
        mul_start = !issued;
        mul_mode  = MUL_Q40;
        mul_a     = 64'(k0);
        mul_b     = y_inn;
      end
      ST_BIAS: begin
        mul_start = !issued;
        mul_mode  = MUL_Q40;
        mul_a     = 64'(k1);
        mul_b     = y_inn;
      end
      ST_P0: begin
        mul_start = !issued;
        mul_mode  = MUL_Q40;
        mul_a     = 64'(k0);
        mul_b     = 64'(p00o);
      end
      ST_P1: begin
        mul_start = !issued;
        mul_mode  = MUL_Q40;
        mul_a     = 64'(k0);
        mul_b     = 64'(p01o);
      end
      ST_P2: begin
        mul_start = !issued;
        mul_mode  = MUL_Q40;
        mul_a     = 64'(k1);
        mul_b     = 64'(p00o);
      end
      ST_P3: begin
        mul_start = !issued;
        mul_mode  = MUL_Q40;
        mul_a     = 64'(k1);
        mul_b     = 64'(p01o);
      end
      ST_OUT: begin
        mul_start = !issued;
        mul_mode  = MUL_Q16;
        mul_a     = 64'(ang);
        mul_b     = 64'sd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      issued    <= 1'b0;
      out_valid <= 1'b0;
      q_angle   <= QANGLE_RST;
      q_bias    <= QBIAS_RST;
      r_noise   <= RNOISE_RST;
      bias      <= '0;
      p00       <= '0;
      p01       <= '0;
      p10       <= '0;
      p11       <= '0;
    end else begin
      state <= state_next;
      if (wr_en) begin
        case (wr_index)
          REG_QANGLE: q_angle <= wr_data;
          REG_QBIAS:  q_bias  <= wr_data;
          REG_RNOISE: r_noise <= wr_data;
          default: ;
        endcase
      end
      if (unit_done) begin
        issued <= 1'b0;
      end else if (mul_start || div_start) begin
        issued <= 1'b1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: if (in_fire) begin
          ainw <= 64'($signed(s_axis_tdata[31:0])) <<< 16;
          rate <= (64'($signed(s_axis_tdata[63:32])) <<< 16) - 64'(bias);
          accw <= 64'($signed(s_axis_tdata[95:64])) <<< 16;
          dt   <= $signed({39'd0, (ts > DT_ONE) ? DT_ONE : ts});
          sat  <= 1'b0;
        end
        ST_RATE: if (mul_done) begin
          ang <= cl.val;
          sat <= sat | mul_sat | cl.sat;
        end
        ST_T: if (mul_done) begin
          tt  <= mul_res;
          sat <= sat | mul_sat;
        end
        ST_INNER: if (mul_done) begin
          p00 <= cl.val;
          p01 <= cl1.val;
          p10 <= cl2.val;
          sat <= sat | mul_sat | cl.sat | cl1.sat | cl2.sat;
        end
        ST_PQB: if (mul_done) begin
          p11 <= cl.val;
          sat <= sat | mul_sat | cl.sat;
        end
        ST_K0: if (div_done) begin
          k0  <= div_res;
          sat <= sat | div_sat;
        end
        ST_K1: if (div_done) begin
          k1    <= div_res;
          // innovation against the predicted angle, shared by both corrections
          y_inn <= accw - 64'(ang);
          sat   <= sat | div_sat;
        end
        ST_ANG: if (mul_done) begin
          ang <= cl.val;
          sat <= sat | mul_sat | cl.sat;
        end
        ST_BIAS: if (mul_done) begin
          bias <= cl.val;
          p00o <= p00;
          p01o <= p01;
          sat  <= sat | mul_sat | cl.sat;
        end
        ST_P0: if (mul_done) begin
          p00 <= cl.val;
          sat <= sat | mul_sat | cl.sat;
        end
        ST_P1: if (mul_done) begin
          p01 <= cl.val;
          sat <= sat | mul_sat | cl.sat;
        end
        ST_P2: if (mul_done) begin
          p10 <= cl.val;
          sat <= sat | mul_sat | cl.sat;
        end
        ST_P3: if (mul_done) begin
          p11 <= cl.val;
          sat <= sat | mul_sat | cl.sat;
        end
        ST_OUT: if (mul_done) begin
          sat <= sat | mul_sat;
        end
        ST_DONE: if (load) begin
          // multiplier result holds the rounded angle until the next start
          out_angle <= mul_res[31:0];
          out_sat   <= sat;
        end
        default: ;
      endcase
    end
  end

  abkf_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .mode  (mul_mode),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mul_res),
    .sat   (mul_sat)
  );

  abkf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .n     (div_n),
    .d     (div_d),
    .done  (div_done),
    .res   (div_res),
    .sat   (div_sat)
  );

  `ABKF_ASSERT_NEXT(a_start_seq, in_fire, state == ST_RATE, "item accepted but sequencer idle")
  `ABKF_ASSERT_NOW(a_done_issued, unit_done, issued, "unit finished without a request")
  `ABKF_ASSERT_NEXT(a_load_valid, load, m_axis_tvalid, "result load lost")

endmodule

// File: tb/angle_bias_kalman_filter_chk.sv
// Checker for the angle/bias Kalman filter: watches the input, output and register write ports,
// predicts each fused angle and saturation flag, and compares them in order.
// Depends on abkf_pkg.
`timescale 1ns / 1ps
module angle_bias_kalman_filter_chk
  import abkf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [31:0]  m_axis_tdata,
  input  logic [0:0]   m_axis_tuser,
  input  logic         wr_en,
  input  logic [1:0]   wr_index,
  input  logic [CfgW-1:0] wr_data,
  output int           pending,
  output int           errors,
  output int           n_results,
  output int           n_sat
);

  typedef struct {
    logic [31:0] angle;
    logic        sat;
  } fused_t;

  fused_t fused_q[$];

  logic [CfgW-1:0] q_angle, q_bias, r_noise;
  longint bias;
  longint pcov[4];
  bit step_sat;

  localparam longint LIM47 = 64'sd140737488355327;

  function automatic longint clip_48(longint v);
    if (v > LIM47) begin
      step_sat = 1;
      return LIM47;
    end
    if (v < -LIM47 - 1) begin
      step_sat = 1;
      return -LIM47 - 1;
    end
    return v;
  endfunction

  // (a*b) >> sh, rounded half away from zero, clipped to w bits signed
  function automatic longint mul_round(longint a, longint b, int sh, int w);
    logic [127:0] p;
    logic [63:0] x, y, lim;
    bit neg;
    neg = (a < 0) != (b < 0);
    x = (a < 0) ? -a : a;
    y = (b < 0) ? -b : b;
    p = {64'd0, x} * {64'd0, y};
    p = (p + (128'd1 << (sh - 1))) >> sh;
    lim = neg ? (64'd1 << (w - 1)) : (64'd1 << (w - 1)) - 64'd1;
    if (p > {64'd0, lim}) begin
      step_sat = 1;
      p = {64'd0, lim};
    end
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  // n * 2^40 / d, truncated toward zero; zero gain when d is zero
  function automatic longint gain_div(longint n, longint d);
    logic [127:0] q;
    logic [63:0] un, ud;
    bit neg;
    if (d == 0) return 0;
    neg = (n < 0) != (d < 0);
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    q = ({64'd0, un} << 40) / {64'd0, ud};
    if (q >= (128'd1 << 47)) begin
      step_sat = 1;
      q = neg ? (128'd1 << 47) : (128'd1 << 47) - 1;
    end
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic fused_t predict_fused(logic [127:0] d);
    longint ain, gr, acc, dt, rate, ang, t, inner, s, k0, k1, y, p00o, p01o;
    logic [24:0] dtu;
    fused_t r;
    step_sat = 0;
    ain = longint'($signed(d[31:0]));
    gr  = longint'($signed(d[63:32]));
    acc = longint'($signed(d[95:64]));
    dtu = d[120:96];
    if (dtu > DT_ONE) dtu = DT_ONE;
    dt = longint'(dtu);

    rate = gr * 65536 - bias;
    ang = clip_48(ain * 65536 + mul_round(dt, rate, 24, 62));

    t = mul_round(dt, pcov[3], 24, 62);
    inner = t - pcov[1] - pcov[2] + longint'(q_angle);
    pcov[0] = clip_48(pcov[0] + mul_round(dt, inner, 24, 62));
    pcov[1] = clip_48(pcov[1] - t);
    pcov[2] = clip_48(pcov[2] - t);
    pcov[3] = clip_48(pcov[3] + mul_round(longint'(q_bias), dt, 24, 62));

    s = pcov[0] + longint'(r_noise);
    k0 = gain_div(pcov[0], s);
    k1 = gain_div(pcov[2], s);

    y = acc * 65536 - ang;
    ang = clip_48(ang + mul_round(k0, y, 40, 62));
    bias = clip_48(bias + mul_round(k1, y, 40, 62));

    p00o = pcov[0];
    p01o = pcov[1];
    pcov[0] = clip_48(pcov[0] - mul_round(k0, p00o, 40, 62));
    pcov[1] = clip_48(pcov[1] - mul_round(k0, p01o, 40, 62));
    pcov[2] = clip_48(pcov[2] - mul_round(k1, p00o, 40, 62));
    pcov[3] = clip_48(pcov[3] - mul_round(k1, p01o, 40, 62));

    r.angle = 32'(mul_round(ang, 1, 16, 32));
    r.sat = step_sat;
    return r;
  endfunction

  assign pending = fused_q.size();

  always @(posedge clk) begin
    fused_t e;
    if (rst) begin
      q_angle <= QANGLE_RST;
      q_bias  <= QBIAS_RST;
      r_noise <= RNOISE_RST;
      bias = 0;
      pcov = '{0, 0, 0, 0};
      fused_q.delete();
      errors = 0;
      n_results = 0;
      n_sat = 0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_QANGLE: q_angle <= wr_data;
          REG_QBIAS:  q_bias  <= wr_data;
          REG_RNOISE: r_noise <= wr_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        fused_q.push_back(predict_fused(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (m_axis_tuser[0]) n_sat++;
        if (fused_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: actual angle %h sat %b",
                   $time, m_axis_tdata, m_axis_tuser[0]);
        end else begin
          e = fused_q.pop_front();
          if (m_axis_tdata !== e.angle) begin
            errors++;
            $display("%0t: angle_out expected %h actual %h", $time, e.angle, m_axis_tdata);
          end
          if (m_axis_tuser[0] !== e.sat) begin
            errors++;
            $display("%0t: saturated expected %b actual %b", $time, e.sat, m_axis_tuser[0]);
          end
        end
      end
    end
  end

endmodule

// File: tb/angle_bias_kalman_filter_tb.sv
// Top of the angle/bias Kalman filter testbench: clock, reset, register writes,
// sensor stimulus with random idling, and the verdict.
// Depends on abkf_pkg, angle_bias_kalman_filter and angle_bias_kalman_filter_chk.
`timescale 1ns / 1ps
module angle_bias_kalman_filter_tb;
  import abkf_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 400;
  localparam longint CYCLE_LIMIT = 4000000;
  localparam logic [CfgW-1:0] CFG_MAX = '1;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [31:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic wr_en = 0;
  logic [1:0] wr_index = '0;
  logic [CfgW-1:0] wr_data = '0;

  int pending, errors, n_results, n_sat;
  int send_idle = 0, recv_idle = 0;
  int n_items = 0;
  longint cycles = 0;

  always #5 clk = ~clk;

  angle_bias_kalman_filter dut (.*);
  angle_bias_kalman_filter_chk chk (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at cycle %0d", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk)
    m_axis_tready <= !rst && ($urandom_range(99) >= recv_idle);

  task automatic send_sample(logic [31:0] ain, logic [31:0] gr, logic [31:0] acc,
                             logic [24:0] dt);
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {7'd0, dt, acc, gr, ain};
    do @(posedge clk); while (!s_axis_tready);
    n_items++;
  endtask

  task automatic drain();
    @(posedge clk);
    s_axis_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CfgW-1:0] val);
    wr_en <= 1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 0;
    @(posedge clk);
  endtask

  task automatic set_noise(logic [CfgW-1:0] qa, logic [CfgW-1:0] qb, logic [CfgW-1:0] rn);
    write_reg(REG_QANGLE, qa);
    write_reg(REG_QBIAS, qb);
    write_reg(REG_RNOISE, rn);
  endtask

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(2 * 180 * 65536)) - 180 * 65536);
    endcase
  endfunction

  function automatic logic [24:0] rand_dt();
    case ($urandom_range(9))
      0: return 25'($urandom);
      1: return DT_ONE;
      default: return 25'($urandom_range(1 << 19));
    endcase
  endfunction

  function automatic logic [CfgW-1:0] rand_noise();
    case ($urandom_range(3))
      0: return 48'({$urandom, $urandom});
      default: return 48'($urandom_range(1 << 30)) << $urandom_range(14);
    endcase
  endfunction

  task automatic random_run(int count);
    logic [31:0] ang;
    ang = 0;
    repeat (count) begin
      // mostly feed the previous output back as the angle, like a real loop
      if ($urandom_range(9) < 7)
        ang = m_axis_tdata;
      else
        ang = rand_q16();
      send_sample(ang, rand_q16(), rand_q16(), rand_dt());
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes with the reset noise values
    send_sample(32'd0, 32'd0, 32'd0, 25'd0);
    send_sample(32'h7fffffff, 32'h7fffffff, 32'h80000000, DT_ONE);
    send_sample(32'h80000000, 32'h80000000, 32'h7fffffff, DT_ONE);
    send_sample(32'h00010000, 32'h00050000, 32'h00020000, 25'h1ffffff);
    send_sample(32'hffff0000, 32'hfffb0000, 32'h00000000, DT_ONE + 25'd1);
    send_sample(32'h7fffffff, 32'h80000000, 32'h80000000, 25'd1);
    send_sample(32'h80000000, 32'h7fffffff, 32'h7fffffff, 25'd16384);
    send_sample(32'h55555555, 32'haaaaaaaa, 32'h55555555, 25'h0aaaaaa);
    send_sample(32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 25'h1555555);
    drain();

    // zero noise: all three noise registers cleared
    set_noise('0, '0, '0);
    write_reg(REG_UNUSED, CFG_MAX);
    send_sample(32'h00030000, 32'h00010000, 32'h00100000, 25'd65536);
    send_sample(32'h80000000, 32'h7fffffff, 32'h7fffffff, DT_ONE);
    send_sample(32'h12345678, 32'hfedcba98, 32'h0, 25'd0);
    drain();

    // maximum noise: covariance clips
    set_noise(CFG_MAX, CFG_MAX, CFG_MAX);
    send_sample(32'h00010000, 32'h00010000, 32'h7fffffff, DT_ONE);
    send_sample(32'h80000000, 32'h80000000, 32'h7fffffff, DT_ONE);
    send_sample(32'h7fffffff, 32'h7fffffff, 32'h80000000, DT_ONE);
    send_sample(32'h0, 32'h0, 32'h0, 25'd8);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase % 3)
        0: begin send_idle = 37; recv_idle = 79; end
        1: begin send_idle = 79; recv_idle = 37; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      case (phase)
        0: set_noise(QANGLE_RST, QBIAS_RST, RNOISE_RST);
        1: set_noise(rand_noise(), rand_noise(), rand_noise());
        2: set_noise('0, rand_noise(), '0);
        3: set_noise(CFG_MAX, '0, rand_noise());
        4: set_noise(rand_noise(), CFG_MAX, CFG_MAX);
        default: set_noise(QANGLE_RST, QBIAS_RST, RNOISE_RST);
      endcase
      random_run(250);
      drain();
    end

    $display("covered %0d items over zero, max, reset and random noise settings", n_items);
    $display("%0d results checked, %0d with saturation flagged", n_results, n_sat);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
